/* sv/pts_pkg.sv */
`default_nettype none

package pts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int RES_MAX   = 8;

    // slot index and task count widths
    localparam int SLOT_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TOTAL_W = $clog2(MAX_TASKS + 1);
    localparam int CNT_W   = $clog2(RES_MAX + 1);

    localparam logic [1:0] CMD_CREATE   = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    localparam logic [1:0] MODE_READY     = 2'd0;
    localparam logic [1:0] MODE_BLOCKED   = 2'd1;
    localparam logic [1:0] MODE_SUSPENDED = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NULL       = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_BAD_PERIOD = 2'd3;

    localparam logic [7:0] PERIOD_RESET = 8'd255;
    localparam logic [7:0] TICK_MAX     = 8'd255;

    typedef struct packed {
        logic start;
        logic create;
        logic tick_step;
        logic disp_step;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last_slot;
        logic hit;
        logic cnt_last;
    } t_dp_status;

endpackage

`default_nettype wire

/* sv/pts_ctrl.sv */
`default_nettype none

module pts_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_command,
    input  wire pts_pkg::t_dp_status i_status,
    output pts_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TICK  = 2'd1;
    localparam logic [1:0] S_DISP  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.start = 1'b1;
                    unique case (i_command)
                        pts_pkg::CMD_CREATE: begin
                            o_cmd.create = 1'b1;
                        end
                        pts_pkg::CMD_TICK: begin
                            if (!i_status.empty) begin
                                n_state = S_TICK;
                            end
                        end
                        pts_pkg::CMD_DISPATCH: begin
                            n_state = i_status.empty ? S_FLUSH : S_DISP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_status.last_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_DISP: begin
                o_cmd.disp_step = 1'b1;
                // stop at the table end or once the result limit is reached
                if (i_status.last_slot || (i_status.hit && i_status.cnt_last)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* sv/pts_dp.sv */
`default_nettype none

module pts_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pts_pkg::t_dp_cmd  i_cmd,
    input  wire logic              i_max_period_we,
    input  wire logic [7:0]        i_max_period,
    input  wire logic [7:0]        i_handle_in,
    input  wire logic [7:0]        i_period_in,
    input  wire logic [1:0]        i_mode_in,
    output pts_pkg::t_dp_status    o_status,
    output logic                   o_strobe,
    output logic [1:0]             o_result_status,
    output logic                   o_found,
    output logic [7:0]             o_handle_out,
    output logic [2:0]             o_slot_out,
    output logic                   o_last
);

    logic [7:0] r_handle [pts_pkg::MAX_TASKS];
    logic [7:0] r_period [pts_pkg::MAX_TASKS];
    logic [7:0] r_tick   [pts_pkg::MAX_TASKS];
    logic [1:0] r_mode   [pts_pkg::MAX_TASKS];

    logic [pts_pkg::TOTAL_W-1:0] r_total;
    logic [pts_pkg::SLOT_W-1:0]  r_idx;
    logic [pts_pkg::CNT_W-1:0]   r_cnt;
    logic [7:0]                  r_max_period;

    logic                        r_pend_vld;
    logic [7:0]                  r_pend_handle;
    logic [pts_pkg::SLOT_W-1:0]  r_pend_slot;

    logic       r_strobe;
    logic [1:0] r_status;
    logic       r_found;
    logic [7:0] r_handle_out;
    logic [2:0] r_slot_out;
    logic       r_last;

    logic [1:0]                 create_status;
    logic [1:0]                 create_mode;
    logic [pts_pkg::SLOT_W-1:0] wr_slot;
    logic [7:0]                 cur_tick;
    logic [7:0]                 cur_period;
    logic [1:0]                 cur_mode;

    assign wr_slot    = r_total[pts_pkg::SLOT_W-1:0];
    assign cur_tick   = r_tick[r_idx];
    assign cur_period = r_period[r_idx];
    assign cur_mode   = r_mode[r_idx];

    always_comb begin
        if (i_handle_in == 8'd0) begin
            create_status = pts_pkg::ST_NULL;
        end else if (r_total >= pts_pkg::TOTAL_W'(pts_pkg::MAX_TASKS)) begin
            create_status = pts_pkg::ST_FULL;
        end else if (i_period_in > r_max_period) begin
            create_status = pts_pkg::ST_BAD_PERIOD;
        end else begin
            create_status = pts_pkg::ST_OK;
        end
        create_mode = (i_mode_in == pts_pkg::MODE_UNUSED) ? pts_pkg::MODE_BLOCKED : i_mode_in;
    end

    assign o_status.empty     = (r_total == '0);
    assign o_status.last_slot = (pts_pkg::TOTAL_W'(r_idx) == r_total - pts_pkg::TOTAL_W'(1));
    assign o_status.hit       = (cur_mode == pts_pkg::MODE_READY);
    assign o_status.cnt_last  = (r_cnt == pts_pkg::CNT_W'(pts_pkg::RES_MAX - 1));

    // task table
    always_ff @(posedge i_clk) begin
        if (i_cmd.create && create_status == pts_pkg::ST_OK) begin
            r_handle[wr_slot] <= i_handle_in;
            r_period[wr_slot] <= i_period_in;
            r_tick[wr_slot]   <= 8'd1;
            r_mode[wr_slot]   <= create_mode;
        end
        if (i_cmd.tick_step && cur_mode != pts_pkg::MODE_SUSPENDED) begin
            if (cur_tick >= cur_period) begin
                r_mode[r_idx] <= pts_pkg::MODE_READY;
                r_tick[r_idx] <= 8'd1;
            end else if (cur_tick != pts_pkg::TICK_MAX) begin
                r_tick[r_idx] <= cur_tick + 8'd1;
            end
        end
        if (i_cmd.disp_step && cur_mode == pts_pkg::MODE_READY) begin
            r_mode[r_idx] <= pts_pkg::MODE_BLOCKED;
        end
    end

    // walk position, dispatch count and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_pend_vld   <= 1'b0;
            r_max_period <= pts_pkg::PERIOD_RESET;
        end else begin
            if (i_max_period_we) begin
                r_max_period <= i_max_period;
            end
            if (i_cmd.create && create_status == pts_pkg::ST_OK) begin
                r_total <= r_total + pts_pkg::TOTAL_W'(1);
            end
            if (i_cmd.start) begin
                r_idx      <= '0;
                r_cnt      <= '0;
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.tick_step || i_cmd.disp_step) begin
                r_idx <= r_idx + pts_pkg::SLOT_W'(1);
            end
            if (i_cmd.disp_step && cur_mode == pts_pkg::MODE_READY) begin
                r_cnt         <= r_cnt + pts_pkg::CNT_W'(1);
                r_pend_vld    <= 1'b1;
                r_pend_handle <= r_handle[r_idx];
                r_pend_slot   <= r_idx;
            end
            if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    // result register; a ready task is held back one find so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.create) begin
                r_strobe     <= 1'b1;
                r_status     <= create_status;
                r_found      <= 1'b0;
                r_handle_out <= 8'd0;
                r_slot_out   <= 3'd0;
                r_last       <= 1'b1;
            end else if (i_cmd.disp_step && cur_mode == pts_pkg::MODE_READY && r_pend_vld) begin
                r_strobe     <= 1'b1;
                r_status     <= pts_pkg::ST_OK;
                r_found      <= 1'b1;
                r_handle_out <= r_pend_handle;
                r_slot_out   <= 3'(r_pend_slot);
                r_last       <= 1'b0;
            end else if (i_cmd.flush) begin
                r_strobe     <= 1'b1;
                r_status     <= pts_pkg::ST_OK;
                r_found      <= r_pend_vld;
                r_handle_out <= r_pend_vld ? r_pend_handle : 8'd0;
                r_slot_out   <= r_pend_vld ? 3'(r_pend_slot) : 3'd0;
                r_last       <= 1'b1;
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_result_status = r_status;
    assign o_found         = r_found;
    assign o_handle_out    = r_handle_out;
    assign o_slot_out      = r_slot_out;
    assign o_last          = r_last;

endmodule

`default_nettype wire

/* sv/periodic_task_scheduler.sv */
`default_nettype none

// Periodic task scheduler: a table of up to eight periodic tasks driven by
// create, tick and dispatch commands. A command transfers when start is high
// and busy is low. Results appear for a single cycle with o_strobe high and
// cannot be stalled, so the receiver must take every strobe. Create answers
// in the cycle after the transfer and leaves busy low. Tick walks the table
// one slot per cycle and gives no result. Dispatch walks the same way and
// then finishes with a flush step; each ready task is reported one find
// later and the final result, or a not-found result, carries o_last.
// Command 3 is taken and ignored. The max_period register must be written
// with i_max_period_we only while the block is idle; the block itself does
// not enforce it.
module periodic_task_scheduler (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_max_period_we,
    input  wire logic [7:0] i_max_period,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_handle_in,
    input  wire logic [7:0] i_period_in,
    input  wire logic [1:0] i_mode_in,
    output logic            o_strobe,
    output logic [1:0]      o_status,
    output logic            o_found,
    output logic [7:0]      o_handle_out,
    output logic [2:0]      o_slot_out,
    output logic            o_last
);

    pts_pkg::t_dp_cmd    dp_cmd;
    pts_pkg::t_dp_status dp_status;

    pts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    pts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_max_period_we (i_max_period_we),
        .i_max_period    (i_max_period),
        .i_handle_in     (i_handle_in),
        .i_period_in     (i_period_in),
        .i_mode_in       (i_mode_in),
        .o_status        (dp_status),
        .o_strobe        (o_strobe),
        .o_result_status (o_status),
        .o_found         (o_found),
        .o_handle_out    (o_handle_out),
        .o_slot_out      (o_slot_out),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

/* sv/pts_checker.sv */
`default_nettype none

module pts_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_command,
    input wire logic       o_strobe,
    input wire logic [1:0] o_status,
    input wire logic       o_found,
    input wire logic       o_last
);

    // a create answers in the next cycle with a single final result
    a_create_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == pts_pkg::CMD_CREATE
        |=> o_strobe && o_last && !o_found)
        else $error("create transfer without a result in the next cycle");

    // a tick transfer never produces a result right after it
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == pts_pkg::CMD_TICK |=> !o_strobe)
        else $error("result after tick transfer");

    // a not-found result, from a create or a dispatch, always carries last
    a_notfound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_found |-> o_last)
        else $error("not-found result without last");

    // dispatch results carry an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_found |-> o_status == pts_pkg::ST_OK)
        else $error("dispatch result with non-ok status");

    // the final result of a command is shown once the block is idle again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final result while still busy");

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_strobe  (o_strobe),
    .o_status  (o_status),
    .o_found   (o_found),
    .o_last    (o_last)
);

`default_nettype wire

/* tb/periodic_task_scheduler_test.sv */
`timescale 1ns / 100ps

module periodic_task_scheduler_test;
    import pts_pkg::*;

    localparam logic [1:0] CMD_IGNORED = 2'd3;
    // longest walk is a full-table dispatch, and this settle time covers it
    localparam int SETTLE_CYCLES = 2 * MAX_TASKS + 4;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 76;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] handle;
        logic [2:0] slot;
        logic       last;
    } sched_result_t;

    typedef struct packed {
        logic       cfg_write;
        logic [1:0] command;
        logic [7:0] handle;
        logic [7:0] period;
        logic [1:0] mode;
        logic       typed;
        logic [1:0] status;
    } directed_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_max_period_we = 1'b0;
    logic [7:0] i_max_period = 8'd0;
    logic [1:0] i_command = CMD_TICK;
    logic [7:0] i_handle_in = 8'd0;
    logic [7:0] i_period_in = 8'd0;
    logic [1:0] i_mode_in = MODE_READY;
    logic       o_strobe;
    logic [1:0] o_status;
    logic       o_found;
    logic [7:0] o_handle_out;
    logic [2:0] o_slot_out;
    logic       o_last;

    // mirror of the task table
    logic [7:0] tbl_handle [MAX_TASKS];
    logic [7:0] tbl_period [MAX_TASKS];
    logic [7:0] tbl_count  [MAX_TASKS];
    logic [1:0] tbl_mode   [MAX_TASKS];
    int         tbl_total = 0;
    logic [7:0] limit_period = PERIOD_RESET;

    sched_result_t walk_results [RES_MAX];
    sched_result_t pending_results [$];
    directed_row_t directed_rows [$];
    int            mismatches = 0;

    periodic_task_scheduler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_max_period_we (i_max_period_we),
        .i_max_period    (i_max_period),
        .i_command       (i_command),
        .i_handle_in     (i_handle_in),
        .i_period_in     (i_period_in),
        .i_mode_in       (i_mode_in),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_handle_out    (o_handle_out),
        .o_slot_out      (o_slot_out),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #200000;
        $display("periodic_task_scheduler_test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    // applies one command to the table mirror, fills walk_results, returns the count
    function automatic int schedule_step(input logic [1:0] cmd, input logic [7:0] handle,
                                         input logic [7:0] period, input logic [1:0] mode);
        int         n;
        logic [1:0] st;
        n = 0;
        case (cmd)
            CMD_CREATE: begin
                if (handle == 8'd0) begin
                    st = ST_NULL;
                end else if (tbl_total >= MAX_TASKS) begin
                    st = ST_FULL;
                end else if (period > limit_period) begin
                    st = ST_BAD_PERIOD;
                end else begin
                    tbl_handle[tbl_total] = handle;
                    tbl_period[tbl_total] = period;
                    tbl_count[tbl_total]  = 8'd1;
                    tbl_mode[tbl_total]   = (mode == MODE_UNUSED) ? MODE_BLOCKED : mode;
                    tbl_total++;
                    st = ST_OK;
                end
                walk_results[0] = '{st, 1'b0, 8'd0, 3'd0, 1'b1};
                n = 1;
            end
            CMD_TICK: begin
                for (int i = 0; i < tbl_total; i++) begin
                    if (tbl_mode[i] != MODE_SUSPENDED) begin
                        if (tbl_count[i] >= tbl_period[i]) begin
                            tbl_mode[i]  = MODE_READY;
                            tbl_count[i] = 8'd1;
                        end else if (tbl_count[i] != TICK_MAX) begin
                            tbl_count[i] = tbl_count[i] + 8'd1;
                        end
                    end
                end
            end
            CMD_DISPATCH: begin
                for (int i = 0; i < tbl_total && n < RES_MAX; i++) begin
                    if (tbl_mode[i] == MODE_READY) begin
                        walk_results[n] = '{ST_OK, 1'b1, tbl_handle[i], 3'(i), 1'b0};
                        tbl_mode[i] = MODE_BLOCKED;
                        n++;
                    end
                end
                if (n == 0) begin
                    walk_results[0] = '{ST_OK, 1'b0, 8'd0, 3'd0, 1'b1};
                    n = 1;
                end else begin
                    walk_results[n - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // returns at the edge where the command transfers
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] handle,
                             input logic [7:0] period, input logic [1:0] mode,
                             input logic typed, input sched_result_t typed_result);
        int n;
        start       <= 1'b1;
        i_command   <= cmd;
        i_handle_in <= handle;
        i_period_in <= period;
        i_mode_in   <= mode;
        do @(posedge i_clk); while (busy !== 1'b0);
        n = schedule_step(cmd, handle, period, mode);
        if (typed) begin
            pending_results.push_back(typed_result);
        end else begin
            for (int k = 0; k < n; k++) begin
                pending_results.push_back(walk_results[k]);
            end
        end
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // a tick gives no result, so settle long enough for its walk to finish too
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_period(input logic [7:0] value);
        drain_results();
        i_max_period_we <= 1'b1;
        i_max_period    <= value;
        @(posedge i_clk);
        i_max_period_we <= 1'b0;
        limit_period = value;
    endtask

    task automatic add_row(input logic cfg_write, input logic [1:0] cmd,
                           input logic [7:0] handle, input logic [7:0] period,
                           input logic [1:0] mode, input logic typed, input logic [1:0] status);
        directed_row_t row;
        row = '{cfg_write, cmd, handle, period, mode, typed, status};
        directed_rows.push_back(row);
    endtask

    always @(posedge i_clk) begin
        sched_result_t want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d handle %0d slot %0d",
                                          o_status, o_handle_out, o_slot_out));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %0d, want %0d", o_found, want.found));
                if (o_handle_out !== want.handle)
                    report_mismatch($sformatf("handle %0d, want %0d", o_handle_out, want.handle));
                if (o_slot_out !== want.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", o_slot_out, want.slot));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", o_last, want.last));
            end
        end
    end

    initial begin
        directed_row_t row;
        sched_result_t typed_result;
        logic [1:0]    cmd;
        logic [7:0]    handle;
        logic [7:0]    period;
        logic [1:0]    mode;
        int            pick;
        int            idle_pct;

        // empty table, then creates under the reset limit
        add_row(0, CMD_DISPATCH, 8'h00, 8'h00, MODE_READY,     1, ST_OK);
        add_row(0, CMD_TICK,     8'hFF, 8'hFF, MODE_UNUSED,    0, ST_OK);
        add_row(0, CMD_CREATE,   8'h00, 8'h05, MODE_READY,     1, ST_NULL);
        add_row(0, CMD_CREATE,   8'hFF, 8'hFF, MODE_READY,     1, ST_OK);
        add_row(0, CMD_CREATE,   8'h01, 8'h00, MODE_BLOCKED,   0, ST_OK);
        add_row(0, CMD_CREATE,   8'h80, 8'h02, MODE_SUSPENDED, 0, ST_OK);
        add_row(0, CMD_CREATE,   8'h55, 8'h03, MODE_UNUSED,    0, ST_OK);
        add_row(0, CMD_IGNORED,  8'hAA, 8'h55, MODE_BLOCKED,   0, ST_OK);
        add_row(0, CMD_DISPATCH, 8'h00, 8'h00, MODE_READY,     0, ST_OK);
        add_row(0, CMD_TICK,     8'h00, 8'h00, MODE_READY,     0, ST_OK);
        add_row(0, CMD_DISPATCH, 8'hFF, 8'hFF, MODE_UNUSED,    0, ST_OK);
        add_row(0, CMD_TICK,     8'h00, 8'h00, MODE_READY,     0, ST_OK);
        add_row(0, CMD_TICK,     8'h00, 8'h00, MODE_READY,     0, ST_OK);
        add_row(0, CMD_DISPATCH, 8'h00, 8'h00, MODE_READY,     0, ST_OK);
        // limit at zero: only period zero gets in
        add_row(1, CMD_TICK,     8'h00, 8'h00, MODE_READY,     0, ST_OK);
        add_row(0, CMD_CREATE,   8'h7F, 8'h01, MODE_READY,     1, ST_BAD_PERIOD);
        add_row(0, CMD_CREATE,   8'h7F, 8'h00, MODE_READY,     0, ST_OK);
        add_row(1, CMD_TICK,     8'h00, 8'hFF, MODE_READY,     0, ST_OK);
        add_row(0, CMD_CREATE,   8'h00, 8'hFF, MODE_UNUSED,    1, ST_NULL);
        add_row(0, CMD_TICK,     8'h00, 8'h00, MODE_READY,     0, ST_OK);
        add_row(0, CMD_DISPATCH, 8'h00, 8'h00, MODE_READY,     0, ST_OK);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.cfg_write) begin
                set_max_period(row.period);
            end else begin
                typed_result = '{row.status, 1'b0, 8'd0, 3'd0, 1'b1};
                send_item(row.command, row.handle, row.period, row.mode, row.typed,
                          typed_result);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p % 3)
                0: set_max_period(8'($urandom_range(255)));
                1: set_max_period(8'd0);
                default: set_max_period(8'd255);
            endcase
            idle_pct = (p == PHASES - 1) ? 0 : $urandom_range(10, 50);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(99);
                if (pick < 15) cmd = CMD_CREATE;
                else if (pick < 58) cmd = CMD_TICK;
                else if (pick < 95) cmd = CMD_DISPATCH;
                else cmd = CMD_IGNORED;
                handle = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                period = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(6));
                mode = 2'($urandom_range(3));
                send_item(cmd, handle, period, mode, 1'b0, '0);
                // bursts mostly in the middle third, none in the last phase
                if (k > PHASE_ITEMS / 3 && k < 2 * PHASE_ITEMS / 3 &&
                    $urandom_range(99) < idle_pct) begin
                    idle_sender($urandom_range(1, 12));
                end else if (k < PHASE_ITEMS / 3 && idle_pct > 0 &&
                             $urandom_range(7) == 0) begin
                    idle_sender($urandom_range(1, 12));
                end
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("periodic_task_scheduler_test passed");
        end else begin
            $display("periodic_task_scheduler_test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/pts_pkg.sv
sv/pts_ctrl.sv
sv/pts_dp.sv
sv/periodic_task_scheduler.sv
sv/pts_checker.sv
tb/periodic_task_scheduler_test.sv
